### design/sbm_pkg.sv
// Shared types and constants for the serial loaded bank mapper.
`timescale 1ns / 1ps
`default_nettype none
package sbm_pkg;

  typedef enum logic [1:0] {
    CMD_CPU_WRITE = 2'd0,
    CMD_CPU_READ  = 2'd1,
    CMD_PPU_READ  = 2'd2,
    CMD_PPU_WRITE = 2'd3
  } sbm_cmd_t;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_PRG  = 2'd1;
  localparam logic [1:0] TGT_CHR  = 2'd2;

  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  localparam logic [4:0] PRG_COUNT_RESET = 5'd2;
  localparam logic [4:0] CHR_COUNT_RESET = 5'd0;
  localparam logic [4:0] CONTROL_RESET   = 5'h0C;
  localparam logic [4:0] PRG_MODE_FORCE  = 5'h0C;

  // Target register selected by address bits 14..13 on the fifth serial bit.
  localparam logic [1:0] SEL_CONTROL  = 2'd0;
  localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
  localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
  localparam logic [1:0] SEL_PRG_BANK = 2'd3;

  localparam logic [2:0] SERIAL_LAST_BIT = 3'd4;

  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] prg_reg;
  } sbm_state_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [17:0] mapped_offset;
    logic        chr_write_enable;
    logic [7:0]  chr_write_data;
    logic        bad_address;
  } sbm_result_t;

endpackage
`default_nettype wire

### design/sbm_regs.sv
// Mapper bank registers and the five-bit serial load shift register.
`timescale 1ns / 1ps
`default_nettype none
module sbm_regs
  import sbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  output sbm_state_t       st,
  output logic [4:0]       control_next
);

  sbm_state_t st_next;
  logic [4:0] shift_bits;
  logic [4:0] shift_bits_next;
  logic [2:0] bits_loaded;
  logic [2:0] bits_loaded_next;
  logic [4:0] assembled;

  assign assembled    = shift_bits | (5'(data[0]) << bits_loaded);
  assign control_next = st_next.control;

  always_comb begin
    st_next          = st;
    shift_bits_next  = shift_bits;
    bits_loaded_next = bits_loaded;
    if (load) begin
      if (data[7]) begin
        shift_bits_next  = '0;
        bits_loaded_next = '0;
        st_next.control  = st.control | PRG_MODE_FORCE;
      end else if (bits_loaded == SERIAL_LAST_BIT) begin
        shift_bits_next  = '0;
        bits_loaded_next = '0;
        case (addr[14:13])
          SEL_CONTROL:  st_next.control  = assembled;
          SEL_CHR_LOW:  st_next.chr_low  = assembled;
          SEL_CHR_HIGH: st_next.chr_high = assembled;
          SEL_PRG_BANK: st_next.prg_reg  = assembled;
          default:      st_next.prg_reg  = assembled;
        endcase
      end else begin
        shift_bits_next  = assembled;
        bits_loaded_next = bits_loaded + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.control  <= CONTROL_RESET;
      st.chr_low  <= '0;
      st.chr_high <= '0;
      st.prg_reg  <= '0;
      shift_bits  <= '0;
      bits_loaded <= '0;
    end else begin
      st          <= st_next;
      shift_bits  <= shift_bits_next;
      bits_loaded <= bits_loaded_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    bits_loaded <= SERIAL_LAST_BIT)
    else $error("serial bit count out of range");

  a_reset_clear: assert property (@(posedge clk) disable iff (rst)
    load && data[7] |=> bits_loaded == 3'd0 && shift_bits == 5'd0
                        && st.control[3:2] == 2'b11)
    else $error("reset write did not clear the shift register");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(st) && $stable(bits_loaded))
    else $error("mapper state changed without a cpu write");

endmodule
`default_nettype wire

### design/sbm_xlate.sv
// Address translation of one bus access into a program or character offset.
`timescale 1ns / 1ps
`default_nettype none
module sbm_xlate
  import sbm_pkg::*;
#(
  parameter int CHR_RAM_BYTES = 8192
)
(
  input  wire sbm_cmd_t    cmd,
  input  wire logic [15:0] addr,
  input  wire logic [7:0]  data,
  input  wire sbm_state_t  st,
  input  wire logic [4:0]  prg_bank_count,
  input  wire logic [4:0]  chr_bank_count,
  output sbm_result_t      res
);

  localparam logic [17:0] CHR_RAM_MASK = 18'(CHR_RAM_BYTES - 1);

  logic [4:0]  prg_last;
  logic [1:0]  prg_layout;
  logic [3:0]  prg_sel;
  logic [4:0]  prg_page;
  logic [18:0] prg_raw;
  logic [17:0] prg_off;
  logic [16:0] chr_raw;
  logic [17:0] chr_mask;
  logic [17:0] chr_off;
  logic        cpu_window;
  logic        ppu_window;

  assign cpu_window = addr[15];
  assign ppu_window = (addr[15:13] == 3'd0);

  // A zero bank count behaves as one bank.
  assign prg_last   = (prg_bank_count == 5'd0) ? 5'd0 : prg_bank_count - 5'd1;
  assign prg_layout = st.control[3:2];
  assign prg_sel    = st.prg_reg[3:0];

  always_comb begin
    if (!addr[14]) begin
      if (!prg_layout[1])            prg_page = {1'b0, prg_sel[3:1], 1'b0};
      else if (prg_layout == 2'd2)   prg_page = 5'd0;
      else                           prg_page = {1'b0, prg_sel};
    end else begin
      if (!prg_layout[1])            prg_page = {1'b0, prg_sel[3:1], 1'b1};
      else if (prg_layout == 2'd2)   prg_page = {1'b0, prg_sel};
      else                           prg_page = prg_last;
    end
  end

  // Bank size is 16 KiB, so the bank number sits directly above the window bits.
  assign prg_raw = {prg_page, addr[13:0]};
  assign prg_off = 18'(prg_raw & {prg_last, 14'h3FFF});

  always_comb begin
    if (!st.control[4])   chr_raw = {st.chr_low[4:1], addr[12:0]};
    else if (!addr[12])   chr_raw = {st.chr_low, addr[11:0]};
    else                  chr_raw = {st.chr_high, addr[11:0]};
  end

  assign chr_mask = (chr_bank_count == 5'd0) ? CHR_RAM_MASK
                                             : {chr_bank_count - 5'd1, 13'h1FFF};
  assign chr_off  = {1'b0, chr_raw} & chr_mask;

  always_comb begin
    res = '0;
    case (cmd)
      CMD_CPU_WRITE: begin
        res.bad_address = !cpu_window;
      end
      CMD_CPU_READ: begin
        if (!cpu_window) begin
          res.bad_address = 1'b1;
        end else begin
          res.target        = TGT_PRG;
          res.mapped_offset = prg_off;
        end
      end
      CMD_PPU_READ: begin
        if (!ppu_window) begin
          res.bad_address = 1'b1;
        end else begin
          res.target        = TGT_CHR;
          res.mapped_offset = chr_off;
        end
      end
      CMD_PPU_WRITE: begin
        if (!ppu_window) begin
          res.bad_address = 1'b1;
        end else if (chr_bank_count == 5'd0) begin
          res.target           = TGT_CHR;
          res.mapped_offset    = chr_off;
          res.chr_write_enable = 1'b1;
          res.chr_write_data   = data;
        end
      end
      default: res = '0;
    endcase
  end

endmodule
`default_nettype wire

### design/serial_loaded_bank_mapper.sv
// Top level of the serial loaded bank mapper: input and result registers.
// Each bus access is taken into an input register, translated against the current
// bank registers in one pass of logic and held in a result register. A new access
// can be accepted every cycle while the output is not stalled. CPU writes at 0x8000
// and above shift one bit into the serial loader, or reset it when bit 7 is set,
// and update the bank registers as the access leaves the input register, so the
// next access already sees the new banking; the mirroring output of a result
// reflects the control register after that access. Configuration writes take
// effect on the next cycle; the user must make them only while no transfer is in
// flight, as the block does not enforce this. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module serial_loaded_bank_mapper
  import sbm_pkg::*;
#(
  parameter int CHR_RAM_BYTES = 8192
)
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] bus_address,
  input  wire logic [7:0]  write_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       target,
  output logic [17:0]      mapped_offset,
  output logic             chr_write_enable,
  output logic [7:0]       chr_write_data,
  output logic [1:0]       mirroring,
  output logic             bad_address
);

  logic        advance;
  logic        in_take;
  logic        s1_valid;
  sbm_cmd_t    s1_cmd;
  logic [15:0] s1_addr;
  logic [7:0]  s1_data;
  logic [4:0]  prg_bank_count;
  logic [4:0]  chr_bank_count;
  logic        map_load;
  sbm_state_t  st;
  logic [4:0]  control_next;
  sbm_result_t res;
  sbm_result_t out_res;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;
  assign map_load = advance && s1_valid && (s1_cmd == CMD_CPU_WRITE) && s1_addr[15];

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_count <= PRG_COUNT_RESET;
      chr_bank_count <= CHR_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PRG_BANK_COUNT: prg_bank_count <= cfg_data;
        CFG_CHR_BANK_COUNT: chr_bank_count <= cfg_data;
        default:            prg_bank_count <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd  <= sbm_cmd_t'(cmd);
      s1_addr <= bus_address;
      s1_data <= write_value;
    end
  end

  sbm_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .load         (map_load),
    .addr         (s1_addr),
    .data         (s1_data),
    .st           (st),
    .control_next (control_next)
  );

  sbm_xlate #(
    .CHR_RAM_BYTES (CHR_RAM_BYTES)
  ) u_xlate (
    .cmd            (s1_cmd),
    .addr           (s1_addr),
    .data           (s1_data),
    .st             (st),
    .prg_bank_count (prg_bank_count),
    .chr_bank_count (chr_bank_count),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_res   <= res;
      mirroring <= control_next[1:0];
    end
  end

  assign target           = out_res.target;
  assign mapped_offset    = out_res.mapped_offset;
  assign chr_write_enable = out_res.chr_write_enable;
  assign chr_write_data   = out_res.chr_write_data;
  assign bad_address      = out_res.bad_address;

  a_no_target_no_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && target == TGT_NONE |-> mapped_offset == 18'd0)
    else $error("offset given without a memory target");

  a_write_goes_to_chr: assert property (@(posedge clk) disable iff (rst)
    out_valid && chr_write_enable |-> target == TGT_CHR && !bad_address)
    else $error("character write enable without a character target");

  a_bad_has_no_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_address |-> target == TGT_NONE && !chr_write_enable)
    else $error("out-of-window access produced a memory access");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid |=> out_valid)
    else $error("transfer lost between input and result register");

endmodule
`default_nettype wire
